### rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Event codes carried on the kind field
    localparam logic [1:0] KIND_TRIGGER = 2'd0;
    localparam logic [1:0] KIND_RISE    = 2'd1;
    localparam logic [1:0] KIND_FALL    = 2'd2;
    localparam logic [1:0] KIND_POLL    = 2'd3;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned RANGE_W = 23;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd30;

    // Speed of sound numerator: range = (width * 343 mod 2^32) / 2000
    localparam logic [8:0] SPEED_NUM = 9'd343;

    // /2000 is done as >>4 then /125; /125 is a reciprocal multiply,
    // exact for every 28-bit dividend (error term 7 * 2^28 < 2^35).
    localparam int unsigned PRE_SHIFT   = 4;
    localparam int unsigned DIVIDEND_W  = STAMP_W - PRE_SHIFT;
    localparam int unsigned RECIP_W     = 29;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned QUOT_W      = 22;
    localparam int unsigned RECIP_PROD_W = DIVIDEND_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 29'd274877907;

    // One classified event, as handed from the front to the back
    typedef struct packed {
        logic               fire;
        logic               busy;
        logic               fresh;
        logic               good;
        logic [STAMP_W-1:0] width;
    } rec_t;

endpackage

### rtl/uer_front.sv
// Front end: accepts events, keeps measurement state and classifies each event.
module uer_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [1:0]                    kind,
    input  logic [uer_pkg::STAMP_W-1:0]   time_us,
    input  logic [uer_pkg::STAMP_W-1:0]   time_ms,
    input  logic                          cfg_write,
    input  logic [uer_pkg::LIMIT_W-1:0]   cfg_data,
    output uer_pkg::rec_t                 rec
);
    import uer_pkg::*;

    logic               running_reg, running_next;
    logic               rise_seen_reg, rise_seen_next;
    logic               result_new_reg, result_new_next;
    logic               result_valid_reg, result_valid_next;
    logic [STAMP_W-1:0] width_reg, width_next;
    logic [STAMP_W-1:0] rise_stamp_reg, rise_stamp_next;
    logic [STAMP_W-1:0] start_stamp_reg, start_stamp_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [STAMP_W-1:0] elapsed_ms;
    logic               fire;

    assign elapsed_ms = time_ms - start_stamp_reg;

    always_comb
    begin
        running_next      = running_reg;
        rise_seen_next    = rise_seen_reg;
        result_new_next   = result_new_reg;
        result_valid_next = result_valid_reg;
        width_next        = width_reg;
        rise_stamp_next   = rise_stamp_reg;
        start_stamp_next  = start_stamp_reg;
        fire              = 1'b0;
        unique case (kind)
            KIND_TRIGGER:
            begin
                if (!running_reg)
                begin
                    running_next      = 1'b1;
                    rise_seen_next    = 1'b0;
                    result_new_next   = 1'b0;
                    result_valid_next = 1'b0;
                    width_next        = '0;
                    start_stamp_next  = time_ms;
                    fire              = 1'b1;
                end
            end
            KIND_RISE:
            begin
                if (running_reg && !rise_seen_reg)
                begin
                    rise_stamp_next = time_us;
                    rise_seen_next  = 1'b1;
                end
            end
            KIND_FALL:
            begin
                if (running_reg && rise_seen_reg)
                begin
                    width_next        = time_us - rise_stamp_reg;
                    result_valid_next = 1'b1;
                    running_next      = 1'b0;
                    result_new_next   = 1'b1;
                end
            end
            KIND_POLL:
            begin
                if (running_reg && (elapsed_ms > {{(STAMP_W-LIMIT_W){1'b0}}, limit_reg}))
                begin
                    running_next      = 1'b0;
                    result_valid_next = 1'b0;
                    result_new_next   = 1'b1;
                end
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
    end

    assign rec.fire  = fire;
    assign rec.busy  = running_next;
    assign rec.fresh = result_new_next;
    assign rec.good  = result_valid_next;
    assign rec.width = width_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            rise_seen_reg    <= 1'b0;
            result_new_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            width_reg        <= '0;
            rise_stamp_reg   <= '0;
            start_stamp_reg  <= '0;
            limit_reg        <= LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                running_reg      <= running_next;
                rise_seen_reg    <= rise_seen_next;
                result_new_reg   <= result_new_next;
                result_valid_reg <= result_valid_next;
                width_reg        <= width_next;
                rise_stamp_reg   <= rise_stamp_next;
                start_stamp_reg  <= start_stamp_next;
            end
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // a finished result is never reported while a measurement runs
    a_fresh_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(result_new_reg && running_reg))
        else $error("result flagged new while still measuring");

    a_good_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_new_reg)
        else $error("valid result without new flag");

    a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rec.fire) |=> (running_reg && !rise_seen_reg && width_reg == '0))
        else $error("accepted trigger did not start a measurement");

endmodule

### rtl/uer_queue.sv
// Short queue of classified events between the front and back ends.
module uer_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uer_pkg::rec_t push_data,
    input  logic          pop,
    output uer_pkg::rec_t pop_data,
    output logic          full,
    output logic          not_empty
);
    import uer_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

### rtl/uer_back.sv
// Back end: range arithmetic pipeline and output register.
module uer_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  uer_pkg::rec_t                 q_data,
    output logic                          pop,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          fire_pulse,
    output logic                          busy_res,
    output logic                          fresh,
    output logic                          good,
    output logic [uer_pkg::STAMP_W-1:0]   echo_width_us,
    output logic signed [uer_pkg::RANGE_W-1:0] range_mm
);
    import uer_pkg::*;

    logic                    s1_vld_reg, s2_vld_reg, out_vld_reg;
    rec_t                    s1_rec_reg, s2_rec_reg, out_rec_reg;
    logic [STAMP_W-1:0]      prod_reg;
    logic [QUOT_W-1:0]       quot_reg;
    logic [RANGE_W-1:0]      range_reg;
    logic [STAMP_W+8:0]      prod_full;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic                    adv_out, adv2, adv1;

    assign adv_out = !out_vld_reg || !res_stall;
    assign adv2    = !s2_vld_reg || adv_out;
    assign adv1    = !s1_vld_reg || adv2;
    assign pop     = q_valid && adv1;

    // product wraps at 32 bits before the divide
    assign prod_full  = (STAMP_W+9)'(q_data.width) * (STAMP_W+9)'(SPEED_NUM);
    assign recip_prod = RECIP_PROD_W'(prod_reg[STAMP_W-1:PRE_SHIFT])
                        * RECIP_PROD_W'(RECIP_MULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_vld_reg <= q_valid;
            end
            if (adv2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (adv_out)
            begin
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_rec_reg <= q_data;
            prod_reg   <= prod_full[STAMP_W-1:0];
        end
        if (adv2)
        begin
            s2_rec_reg <= s1_rec_reg;
            quot_reg   <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (adv_out)
        begin
            out_rec_reg <= s2_rec_reg;
            range_reg   <= s2_rec_reg.good ? {{(RANGE_W-QUOT_W){1'b0}}, quot_reg} : '1;
        end
    end

    assign res_valid     = out_vld_reg;
    assign fire_pulse    = out_rec_reg.fire;
    assign busy_res      = out_rec_reg.busy;
    assign fresh         = out_rec_reg.fresh;
    assign good          = out_rec_reg.good;
    assign echo_width_us = out_rec_reg.width;
    assign range_mm      = range_reg;

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> s1_vld_reg)
        else $error("popped item lost at the first stage");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && !adv2) |=> (s2_vld_reg && $stable(quot_reg)))
        else $error("blocked stage two changed");

    a_range_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_rec_reg.good) |-> !range_reg[RANGE_W-1])
        else $error("valid range came out negative");

endmodule

### rtl/ultrasonic_echo_ranger_core.sv
// Top level of the ultrasonic echo ranger: front end, queue and back end.
// Path: an event transferred into the queue then passes the s1, s2 and output
// registers of the back end before its result shows on the outputs.
// Throughput: one event per cycle while evt_stall is low; the queue (QUEUE_DEPTH entries) and the
// three back-end stages absorb output stalls before evt_stall rises.
// Reset: rst_n clears the front-end flags and stamps, the queue count and the stage valids;
// the timeout limit returns to 30 ms. No clearing pass is needed.
module ultrasonic_echo_ranger_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               evt_valid,
    output logic                               evt_stall,
    input  logic [1:0]                         kind,
    input  logic [uer_pkg::STAMP_W-1:0]        time_us,
    input  logic [uer_pkg::STAMP_W-1:0]        time_ms,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uer_pkg::LIMIT_W-1:0]        cfg_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               fire_pulse,
    output logic                               busy_res,
    output logic                               fresh,
    output logic                               good,
    output logic [uer_pkg::STAMP_W-1:0]        echo_width_us,
    output logic signed [uer_pkg::RANGE_W-1:0] range_mm
);
    import uer_pkg::*;

    rec_t front_rec;
    rec_t q_data;
    logic accept;
    logic q_full;
    logic q_valid;
    logic pop;

    assign evt_stall = q_full;
    assign accept    = evt_valid && !evt_stall;
    assign cfg_ready = 1'b1;

    uer_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .time_us   (time_us),
        .time_ms   (time_ms),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rec       (front_rec)
    );

    uer_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_rec),
        .pop       (pop),
        .pop_data  (q_data),
        .full      (q_full),
        .not_empty (q_valid)
    );

    uer_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .fire_pulse    (fire_pulse),
        .busy_res      (busy_res),
        .fresh         (fresh),
        .good          (good),
        .echo_width_us (echo_width_us),
        .range_mm      (range_mm)
    );

endmodule

### bench/tb_ultrasonic_echo_ranger_core.sv
// Self-checking bench for ultrasonic_echo_ranger_core: event streams against a predictor of flags, width and range.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger_core;
    import uer_pkg::*;

    localparam logic [STAMP_W-1:0] SOUND_NUM   = 32'd343;
    localparam logic [STAMP_W-1:0] SOUND_DEN   = 32'd2000;
    localparam int unsigned        PHASE_ITEMS = 300;
    localparam int unsigned        MAX_REPORTS = 10;

    typedef struct packed {
        logic               fire;
        logic               busy;
        logic               fresh;
        logic               good;
        logic [STAMP_W-1:0] width;
        logic [RANGE_W-1:0] dist_mm;
    } echo_result_t;

    class echo_scoreboard;
        logic [LIMIT_W-1:0] limit_ms;
        bit                 running;
        bit                 rise_seen;
        bit                 result_new;
        bit                 result_valid;
        logic [STAMP_W-1:0] width_us;
        logic [STAMP_W-1:0] rise_us;
        logic [STAMP_W-1:0] start_ms;
        echo_result_t       due_q[$];
        int unsigned        errors;

        function new();
            limit_ms     = LIMIT_RESET;
            running      = 1'b0;
            rise_seen    = 1'b0;
            result_new   = 1'b0;
            result_valid = 1'b0;
            width_us     = '0;
            rise_us      = '0;
            start_ms     = '0;
            errors       = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit_ms = value;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Updates the measurement state for one accepted event and queues its result
        function void note_event(logic [1:0] k, logic [STAMP_W-1:0] t_us,
                                 logic [STAMP_W-1:0] t_ms);
            echo_result_t       due;
            logic [STAMP_W-1:0] elapsed;
            logic [STAMP_W-1:0] prod;
            logic [STAMP_W-1:0] quot;
            bit                 fire;
            fire    = 1'b0;
            elapsed = t_ms - start_ms;
            case (k)
                KIND_TRIGGER:
                    if (!running) begin
                        running      = 1'b1;
                        rise_seen    = 1'b0;
                        result_new   = 1'b0;
                        result_valid = 1'b0;
                        width_us     = '0;
                        start_ms     = t_ms;
                        fire         = 1'b1;
                    end
                KIND_RISE:
                    if (running && !rise_seen) begin
                        rise_us   = t_us;
                        rise_seen = 1'b1;
                    end
                KIND_FALL:
                    if (running && rise_seen) begin
                        width_us     = t_us - rise_us;
                        result_valid = 1'b1;
                        running      = 1'b0;
                        result_new   = 1'b1;
                    end
                KIND_POLL:
                    if (running && elapsed > STAMP_W'(limit_ms)) begin
                        running      = 1'b0;
                        result_valid = 1'b0;
                        result_new   = 1'b1;
                    end
                default: ;
            endcase
            // product wraps at 32 bits before the divide
            prod          = width_us * SOUND_NUM;
            quot          = prod / SOUND_DEN;
            due.fire      = fire;
            due.busy      = running;
            due.fresh     = result_new;
            due.good      = result_valid;
            due.width     = width_us;
            due.dist_mm   = result_valid ? quot[RANGE_W-1:0] : '1;
            due_q.push_back(due);
        endfunction

        function void check_result(echo_result_t got);
            echo_result_t due;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing outstanding", $time);
                return;
            end
            due = due_q.pop_front();
            if (got !== due) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected fire %b busy %b fresh %b good %b width %h range %0d",
                             due.fire, due.busy, due.fresh, due.good, due.width,
                             $signed(due.dist_mm));
                    $display("  actual   fire %b busy %b fresh %b good %b width %h range %0d",
                             got.fire, got.busy, got.fresh, got.good, got.width,
                             $signed(got.dist_mm));
                end
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      evt_valid;
    logic                      evt_stall;
    logic [1:0]                kind;
    logic [STAMP_W-1:0]        time_us;
    logic [STAMP_W-1:0]        time_ms;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [LIMIT_W-1:0]        cfg_data;
    logic                      res_valid;
    logic                      res_stall;
    logic                      fire_pulse;
    logic                      busy_res;
    logic                      fresh;
    logic                      good;
    logic [STAMP_W-1:0]        echo_width_us;
    logic signed [RANGE_W-1:0] range_mm;

    echo_scoreboard     sb;
    int unsigned        items_sent = 0;
    bit                 tx_calm = 1'b0;
    logic [STAMP_W-1:0] cur_us;
    logic [STAMP_W-1:0] cur_ms;

    ultrasonic_echo_ranger_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt_valid     (evt_valid),
        .evt_stall     (evt_stall),
        .kind          (kind),
        .time_us       (time_us),
        .time_ms       (time_ms),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .fire_pulse    (fire_pulse),
        .busy_res      (busy_res),
        .fresh         (fresh),
        .good          (good),
        .echo_width_us (echo_width_us),
        .range_mm      (range_mm)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Event side: random gap, then hold the item until the transfer
    task automatic send_event(input logic [1:0] k, input logic [STAMP_W-1:0] t_us,
                              input logic [STAMP_W-1:0] t_ms);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid <= 1'b1;
        kind      <= k;
        time_us   <= t_us;
        time_ms   <= t_ms;
        do @(posedge clk); while (evt_stall);
        sb.note_event(k, t_us, t_ms);
        items_sent++;
    endtask

    task automatic drain();
        evt_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    // Edge cases from reset, with the limit still at its reset value
    task automatic directed();
        send_event(KIND_POLL, 32'h0000_0000, 32'hFFFF_FFFF);
        send_event(KIND_RISE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_event(KIND_FALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(KIND_TRIGGER, 32'h0000_0000, 32'hFFFF_FFF0);
        send_event(KIND_TRIGGER, 32'h0000_0001, 32'hFFFF_FFF5);
        send_event(KIND_FALL, 32'h0000_0002, 32'hFFFF_FFF6);
        // elapsed exactly at the limit across the wrap, then one past it
        send_event(KIND_POLL, 32'h0000_0003, 32'hFFFF_FFF0 + STAMP_W'(LIMIT_RESET));
        send_event(KIND_POLL, 32'h0000_0004, 32'hFFFF_FFF1 + STAMP_W'(LIMIT_RESET));
        send_event(KIND_POLL, 32'h0000_0005, 32'h7FFF_FFFF);
        send_event(KIND_TRIGGER, 32'hFFFF_FFFF, 32'h0000_0000);
        send_event(KIND_RISE, 32'hFFFF_FFF0, 32'h0000_0001);
        send_event(KIND_RISE, 32'h0000_0005, 32'h0000_0002);
        send_event(KIND_FALL, 32'h0000_0010, 32'h0000_0003);
        send_event(KIND_FALL, 32'h0000_0020, 32'h0000_0004);
        send_event(KIND_TRIGGER, 32'h0000_0000, 32'hFFFF_FFFF);
        send_event(KIND_RISE, 32'h0000_0000, 32'h0000_0000);
        send_event(KIND_FALL, 32'hFFFF_FFFF, 32'h0000_0001);
        send_event(KIND_TRIGGER, 32'h0000_0000, 32'h1234_5678);
        send_event(KIND_RISE, 32'd100, 32'h1234_5679);
        send_event(KIND_FALL, 32'd100, 32'h1234_567A);
        // width whose product sits just below the 32-bit wrap
        send_event(KIND_TRIGGER, 32'h0000_0000, 32'd5);
        send_event(KIND_RISE, 32'h7FFF_FFFF, 32'd6);
        send_event(KIND_FALL, 32'h7FFF_FFFF + 32'd12521646, 32'd7);
        send_event(KIND_TRIGGER, 32'h5555_5555, 32'h8000_0000);
        send_event(KIND_POLL, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
    endtask

    // One measurement: mostly well-formed echoes or timeouts, some noise
    task automatic run_sequence();
        int unsigned        pick;
        int unsigned        lim;
        logic [STAMP_W-1:0] pulse;
        logic [STAMP_W-1:0] start;
        pick   = $urandom_range(0, 9);
        lim    = 32'(sb.limit_ms);
        cur_us = cur_us + $urandom_range(0, 100000);
        cur_ms = cur_ms + $urandom_range(0, 100);
        if ($urandom_range(0, 19) == 0)
        begin
            cur_us = $urandom;
            cur_ms = $urandom;
        end
        start = cur_ms;
        if (pick < 6)
        begin
            send_event(KIND_TRIGGER, cur_us, start);
            if ($urandom_range(0, 3) == 0)
                send_event(KIND_TRIGGER, $urandom, $urandom);
            if ($urandom_range(0, 2) == 0)
                send_event(KIND_POLL, $urandom, start + $urandom_range(0, lim));
            if ($urandom_range(0, 5) == 0)
                send_event(KIND_FALL, $urandom, $urandom);
            cur_us = cur_us + $urandom_range(1, 5000);
            send_event(KIND_RISE, cur_us, $urandom);
            if ($urandom_range(0, 3) == 0)
                send_event(KIND_RISE, $urandom, $urandom);
            pulse  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40000);
            cur_us = cur_us + pulse;
            send_event(KIND_FALL, cur_us, $urandom);
        end
        else if (pick < 8)
        begin
            send_event(KIND_TRIGGER, cur_us, start);
            repeat ($urandom_range(0, 3))
                send_event(KIND_POLL, $urandom, start + $urandom_range(0, lim));
            if ($urandom_range(0, 1) == 0)
                send_event(KIND_RISE, cur_us + $urandom_range(1, 5000), $urandom);
            send_event(KIND_POLL, $urandom,
                       start + lim + 1 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 1000)));
            cur_ms = start + lim + 1;
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_event(2'($urandom_range(0, 3)), $urandom, $urandom);
        end
    endtask

    task automatic run_phase();
        int unsigned goal;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
            run_sequence();
    endtask

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] limits [4];
        sb        = new();
        rst_n     <= 1'b0;
        evt_valid <= 1'b0;
        kind      <= KIND_TRIGGER;
        time_us   <= '0;
        time_ms   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        cur_us    = $urandom;
        cur_ms    = $urandom;
        limits[0] = 16'h0000;
        limits[1] = 16'hFFFF;
        limits[2] = LIMIT_W'($urandom_range(1, 65534));
        limits[3] = LIMIT_W'($urandom_range(1, 200));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        directed();
        run_phase();
        foreach (limits[i])
        begin
            set_timeout(limits[i]);
            run_phase();
        end
        drain();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: random stall before each transfer, checked at the edge
    initial
    begin : result_sink
        int unsigned hold;
        bit          rx_calm;
        rx_calm   = 1'b0;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rx_calm = !rx_calm;
            hold = rx_calm ? 0 : $urandom_range(0, 13);
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
            sb.check_result(echo_result_t'{fire_pulse, busy_res, fresh, good,
                                           echo_width_us, range_mm});
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
